[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property on the following edge
`define ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

[design/rcs_pkg.sv]
// ----------------------------------------------------------------------------
// rcs_pkg
// Types, codes and widths shared by the redundant channel selector.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int NUM_CH      = 8;
  localparam int CH_W        = 3;
  localparam int TIME_W      = 64;
  localparam int MERIT_W     = 32;
  localparam int CNT_W       = 4;
  localparam int HYST_W      = 31;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_USER_W   = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 168;

  // Operation codes
  localparam logic [1:0] OP_UPDATE   = 2'd0;
  localparam logic [1:0] OP_OVERRIDE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  // Switch reasons
  localparam logic [1:0] WHY_NONE    = 2'd0;
  localparam logic [1:0] WHY_INITIAL = 2'd1;
  localparam logic [1:0] WHY_TIMEOUT = 2'd2;
  localparam logic [1:0] WHY_MERIT   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd3;

  localparam logic [MERIT_W-1:0] MERIT_FLOOR = 32'h8000_0000;

  typedef struct packed {
    logic [31:0]       channel_timeout;
    logic [HYST_W-1:0] merit_hysteresis;
    logic [31:0]       min_switch_interval;
    logic [CNT_W-1:0]  channel_count;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                operation;
    logic [CH_W-1:0]           channel;
    logic signed [MERIT_W-1:0] merit;
    logic                      merit_missing;
    logic [TIME_W-1:0]         now_time;
  } req_t;

  typedef struct packed {
    logic                      status;
    logic [1:0]                switch_reason;
    logic [CH_W-1:0]           active_index;
    logic [TIME_W-1:0]         last_switch_time;
    logic signed [MERIT_W-1:0] channel_merit;
    logic [TIME_W-1:0]         channel_time;
  } rsp_t;

endpackage

[design/rcs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rcs_cfg_regs
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module rcs_cfg_regs import rcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the register index and mask data to the register width
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT:  cfg_nxt.channel_timeout     = cfg_data;
        REG_HYST:     cfg_nxt.merit_hysteresis    = cfg_data[HYST_W-1:0];
        REG_INTERVAL: cfg_nxt.min_switch_interval = cfg_data;
        REG_COUNT:    cfg_nxt.channel_count       = cfg_data[CNT_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_timeout     <= 32'd100000;
      cfg_r.merit_hysteresis    <= 31'd65536;
      cfg_r.min_switch_interval <= 32'd0;
      cfg_r.channel_count       <= 4'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/rcs_core.sv]
// ----------------------------------------------------------------------------
// rcs_core
// Channel tables, active channel state and the switch decision for one
// transaction. The active channel's merit and time are mirrored in their own
// registers so the tables are only read at the addressed channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rcs_core import rcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp
);

  logic [MERIT_W-1:0] merit_tab_r [NUM_CH];
  logic [MERIT_W-1:0] merit_tab_nxt [NUM_CH];
  logic [TIME_W-1:0]  time_tab_r [NUM_CH];
  logic [TIME_W-1:0]  time_tab_nxt [NUM_CH];
  logic [CH_W-1:0]    act_r, act_nxt;
  logic [TIME_W-1:0]  swt_r, swt_nxt;
  logic [MERIT_W-1:0] act_merit_r, act_merit_nxt;
  logic [TIME_W-1:0]  act_time_r, act_time_nxt;

  logic                ch_ok;
  logic                is_act;
  logic [MERIT_W-1:0]  merit_in;
  logic [TIME_W-1:0]   limit;
  logic [TIME_W-1:0]   dead;
  logic signed [33:0]  bar;
  logic signed [33:0]  merit_ext;
  logic                timed_out;
  logic                better;
  logic                do_write;
  logic                do_override;
  logic                bad;
  logic [1:0]          reason;

  // Qualify the channel and prepare the stored merit
  assign ch_ok    = {1'b0, req.channel} < cfg.channel_count;
  assign is_act   = req.channel == act_r;
  assign merit_in = req.merit_missing ? MERIT_FLOOR : req.merit;

  // Timeout and minimum interval checks, sums wrap at 64 bits
  assign limit     = act_time_r + {32'd0, cfg.channel_timeout};
  assign dead      = swt_r + {32'd0, cfg.min_switch_interval};
  assign timed_out = !is_act && (req.now_time > limit);

  // Merit bar formed exactly in 34 bits
  assign bar       = $signed({{2{act_merit_r[MERIT_W-1]}}, act_merit_r})
                   + $signed({3'd0, cfg.merit_hysteresis});
  assign merit_ext = $signed({{2{merit_in[MERIT_W-1]}}, merit_in});
  assign better    = !is_act && (merit_ext > bar) && (req.now_time >= dead);

  // Decode the operation
  always_comb begin
    do_write    = 1'b0;
    do_override = 1'b0;
    bad         = 1'b0;
    reason      = WHY_NONE;
    unique case (req.operation)
      OP_UPDATE: begin
        if (ch_ok && (req.now_time != '0)) begin
          do_write = 1'b1;
          if (swt_r == '0) begin
            reason = WHY_INITIAL;
          end else if (timed_out) begin
            reason = WHY_TIMEOUT;
          end else if (better) begin
            reason = WHY_MERIT;
          end
        end else begin
          bad = 1'b1;
        end
      end
      OP_OVERRIDE: begin
        do_override = ch_ok;
        bad         = !ch_ok;
      end
      OP_READ: begin
        bad = !ch_ok;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  // Next state: write the addressed entry, move the active channel
  always_comb begin
    merit_tab_nxt = merit_tab_r;
    time_tab_nxt  = time_tab_r;
    act_nxt       = act_r;
    swt_nxt       = swt_r;
    act_merit_nxt = act_merit_r;
    act_time_nxt  = act_time_r;
    if (do_write) begin
      merit_tab_nxt[req.channel] = merit_in;
      time_tab_nxt[req.channel]  = req.now_time;
      if (reason != WHY_NONE) begin
        act_nxt = req.channel;
        swt_nxt = req.now_time;
      end
      if ((reason != WHY_NONE) || is_act) begin
        act_merit_nxt = merit_in;
        act_time_nxt  = req.now_time;
      end
    end else if (do_override) begin
      act_nxt       = req.channel;
      swt_nxt       = req.now_time;
      act_merit_nxt = merit_tab_r[req.channel];
      act_time_nxt  = time_tab_r[req.channel];
    end
  end

  // Result of the transaction, showing state after the operation
  always_comb begin
    rsp.status           = bad;
    rsp.switch_reason    = reason;
    rsp.active_index     = act_nxt;
    rsp.last_switch_time = swt_nxt;
    rsp.channel_merit    = bad ? '0 : merit_tab_nxt[req.channel];
    rsp.channel_time     = bad ? '0 : time_tab_nxt[req.channel];
  end

  // Commit state only when a transaction is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        merit_tab_r[i] <= '0;
        time_tab_r[i]  <= '0;
      end
      act_r       <= '0;
      swt_r       <= '0;
      act_merit_r <= '0;
      act_time_r  <= '0;
    end else if (fire) begin
      merit_tab_r <= merit_tab_nxt;
      time_tab_r  <= time_tab_nxt;
      act_r       <= act_nxt;
      swt_r       <= swt_nxt;
      act_merit_r <= act_merit_nxt;
      act_time_r  <= act_time_nxt;
    end
  end

  // Mirror of the active entry always matches the tables
  `ASSERT_CLK(a_mirror_merit, act_merit_r == merit_tab_r[act_r], "active merit mirror stale")
  `ASSERT_CLK(a_mirror_time, act_time_r == time_tab_r[act_r], "active time mirror stale")
  // A rejected transaction leaves the selection untouched
  `ASSERT_NEXT(a_bad_hold, fire && rsp.status, $stable(act_r) && $stable(swt_r), "bad op changed state")
  // A switch stamps the switch time with the update time
  `ASSERT_NEXT(a_switch_time, fire && (rsp.switch_reason != WHY_NONE), swt_r == $past(req.now_time), "switch time not stamped")

endmodule

[design/redundant_channel_selector.sv]
// ----------------------------------------------------------------------------
// redundant_channel_selector
// Chooses the active channel among up to eight redundant channels, with
// timeout and merit hysteresis, and returns one result per transaction.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle when the result side keeps up.
// An accepted transaction is held in the input register, and the switch
// decision runs from it (one 64-bit add and compare for the timeout, one for
// the switch interval, a 34-bit merit compare). When the transaction leaves
// the input register, the result register is loaded together with the
// channel tables. out_tvalid comes from the result register, so a result
// passes the input register and then the result register. A stalled output
// holds one result and one further transaction in the input register before
// in_tready drops. Configuration writes take effect on the next cycle and
// must be made while idle.
module redundant_channel_selector import rcs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // channel[2:0], merit[34:3], merit_missing[35], now_time[99:36]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [IN_USER_W-1:0]   in_tuser,
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // status[0], switch_reason[2:1], active_index[5:3], last_switch_time[69:6],
  // channel_merit[101:70], channel_time[165:102]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // Configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  req_t in_req;
  req_t s1_req_r;
  logic s1_valid_r;
  rsp_t rsp;
  rsp_t out_rsp_r;
  logic out_valid_r;
  logic advance;
  logic fire;

  rcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Unpack the input transaction
  always_comb begin
    in_req.operation     = in_tuser[1:0];
    in_req.channel       = in_tdata[2:0];
    in_req.merit         = in_tdata[34:3];
    in_req.merit_missing = in_tdata[35];
    in_req.now_time      = in_tdata[99:36];
  end

  // Advance when the result register is free or being drained
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r <= in_req;
    end
  end

  rcs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (fire),
    .req   (s1_req_r),
    .rsp   (rsp)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_rsp_r <= rsp;
    end
  end

  // Pack the result transaction
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_rsp_r.channel_time, out_rsp_r.channel_merit,
                       out_rsp_r.last_switch_time, out_rsp_r.active_index,
                       out_rsp_r.switch_reason, out_rsp_r.status};

endmodule

[dv/redundant_channel_selector_tb.sv]
// ----------------------------------------------------------------------------
// redundant_channel_selector_tb
// Self-checking bench for the redundant channel selector. A short directed
// script is walked first: reset state, rejected arguments, each switch cause,
// overrides and 64-bit wrap. Several randomised phases follow, each with its
// own register setting. Every accepted transaction is run through a local
// selection model, and each result is compared field by field in order.
// ----------------------------------------------------------------------------
module redundant_channel_selector_tb;
  import rcs_pkg::*;

  // Operation code that the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    req_t                  item;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    typed;
    rsp_t                  want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Register copies kept by the bench
  logic [31:0]       timeout_us   = 32'd100000;
  logic [HYST_W-1:0] hysteresis   = 31'd65536;
  logic [31:0]       interval_us  = 32'd0;
  logic [CNT_W-1:0]  chan_count   = 4'd1;

  // Selection state kept by the bench
  logic signed [MERIT_W-1:0] merit_tab [NUM_CH];
  logic [TIME_W-1:0]         stamp_tab [NUM_CH];
  logic [CH_W-1:0]           active_ch   = '0;
  logic [TIME_W-1:0]         switched_at = '0;

  rsp_t          awaited [$];
  script_row_t   script [$];
  logic [63:0]   now_us    = 64'd1;
  bit            src_gaps  = 1'b1;
  bit            sink_gaps = 1'b1;
  int unsigned   sink_hold = 0;
  int unsigned   n_errors  = 0;
  int unsigned   n_sent    = 0;
  int unsigned   n_checked = 0;
  int unsigned   n_rejected = 0;
  int unsigned   n_override = 0;
  int unsigned   reason_tally [4] = '{0, 0, 0, 0};

  redundant_channel_selector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 8 unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Work out the result of one transaction and advance the local state
  function automatic rsp_t decide_channel(req_t r);
    rsp_t              o;
    logic [CH_W-1:0]   act;
    logic [TIME_W-1:0] limit;
    logic [TIME_W-1:0] dead;
    longint            bar;
    bit                valid;
    o = '0;
    valid = (r.channel < chan_count) && (r.channel < NUM_CH);
    if (r.operation == OP_UPDATE && valid && r.now_time != '0) begin
      act = active_ch;
      merit_tab[r.channel] = r.merit_missing ? MERIT_FLOOR : r.merit;
      stamp_tab[r.channel] = r.now_time;
      if (switched_at == '0) o.switch_reason = WHY_INITIAL;
      // Timeout: active channel silent for too long, sum wraps at 64 bits
      if (o.switch_reason == WHY_NONE && r.channel != act) begin
        limit = stamp_tab[act] + TIME_W'(timeout_us);
        if (r.now_time > limit) o.switch_reason = WHY_TIMEOUT;
      end
      // Better merit: exact sum against hysteresis, wrapped interval check
      if (o.switch_reason == WHY_NONE && r.channel != act) begin
        bar  = longint'(merit_tab[act]) + longint'(hysteresis);
        dead = switched_at + TIME_W'(interval_us);
        if (longint'(merit_tab[r.channel]) > bar && r.now_time >= dead)
          o.switch_reason = WHY_MERIT;
      end
      if (o.switch_reason != WHY_NONE) begin
        active_ch   = r.channel;
        switched_at = r.now_time;
      end
    end else if (r.operation == OP_OVERRIDE && valid) begin
      active_ch   = r.channel;
      switched_at = r.now_time;
    end else if (r.operation == OP_READ && valid) begin
      // state left as it is
    end else begin
      o.status = 1'b1;
      valid    = 1'b0;
    end
    o.active_index     = active_ch;
    o.last_switch_time = switched_at;
    if (valid) begin
      o.channel_merit = merit_tab[r.channel];
      o.channel_time  = stamp_tab[r.channel];
    end
    return o;
  endfunction

  // Draw a random transaction, mostly on channels in use with rising time
  function automatic req_t random_item();
    req_t        r;
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    r.operation = (pick < 70) ? OP_UPDATE : (pick < 82) ? OP_OVERRIDE :
                  (pick < 94) ? OP_READ : OP_UNUSED;
    top = (chan_count == 0 || chan_count > NUM_CH) ? NUM_CH - 1 : chan_count - 1;
    if ($urandom_range(0, 99) < 88) r.channel = CH_W'($urandom_range(0, top));
    else r.channel = CH_W'($urandom_range(0, NUM_CH - 1));
    pick = $urandom_range(0, 99);
    if (pick < 4)      r.merit = $urandom;
    else if (pick < 6) r.merit = 32'h7FFF_FFFF;
    else if (pick < 8) r.merit = 32'h8000_0000;
    else               r.merit = $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
    r.merit_missing = ($urandom_range(0, 99) < 8);
    now_us = now_us + $urandom_range(1, 400);
    pick = $urandom_range(0, 99);
    if (pick < 3)      r.now_time = '0;
    else if (pick < 6) r.now_time = {$urandom, $urandom};
    else               r.now_time = now_us;
    return r;
  endfunction

  // Script builders for the directed part
  function automatic void plan_item(logic [1:0] op, logic [CH_W-1:0] ch,
                                    logic [31:0] merit, logic miss, logic [63:0] t);
    script_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = '{op, ch, merit, miss, t};
    script.push_back(row);
  endfunction

  function automatic void plan_checked(logic [1:0] op, logic [CH_W-1:0] ch,
                                       logic [31:0] merit, logic miss, logic [63:0] t,
                                       rsp_t want);
    plan_item(op, ch, merit, miss, t);
    script[$].typed = 1'b1;
    script[$].want  = want;
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    script_row_t row;
    row = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    script.push_back(row);
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    if (n_errors <= 25)
      $display("mismatch at %0t, result %0d: %s got %h expected %h",
               $realtime, n_checked, what, got, want);
  endtask

  // Offer one transaction, then queue its expected result once accepted
  task automatic offer(req_t r, bit typed, rsp_t want);
    int unsigned gap;
    rsp_t        model;
    gap = src_gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.operation;
    in_tdata  <= {4'b0, r.now_time, r.merit_missing, r.merit, r.channel};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model = decide_channel(r);
    awaited.push_back(typed ? want : model);
    n_sent++;
    if (model.status) n_rejected++;
    else if (r.operation == OP_OVERRIDE) n_override++;
    reason_tally[model.switch_reason]++;
  endtask

  // Drop valid and wait for every outstanding result, plus pipeline slack
  task automatic settle();
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TIMEOUT:  timeout_us  = val;
      REG_HYST:     hysteresis  = val[HYST_W-1:0];
      REG_INTERVAL: interval_us = val;
      REG_COUNT:    chan_count  = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Result side: draw a wait after each transaction, honour long holds
  initial begin : result_sink
    int unsigned pause;
    pause = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) pause = sink_gaps ? $urandom_range(0, 4) : 0;
      if (sink_hold != 0) begin
        pause     = sink_hold;
        sink_hold = 0;
      end
      if (pause != 0) begin
        out_tready <= 1'b0;
        pause--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    rsp_t got;
    rsp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status           = out_tdata[0];
      got.switch_reason    = out_tdata[2:1];
      got.active_index     = out_tdata[5:3];
      got.last_switch_time = out_tdata[69:6];
      got.channel_merit    = out_tdata[101:70];
      got.channel_time     = out_tdata[165:102];
      if (awaited.size() == 0) begin
        flag_mismatch("result with nothing awaited", 64'(got.active_index), '0);
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", 64'(got.status), 64'(want.status));
        if (got.switch_reason !== want.switch_reason)
          flag_mismatch("switch_reason", 64'(got.switch_reason), 64'(want.switch_reason));
        if (got.active_index !== want.active_index)
          flag_mismatch("active_index", 64'(got.active_index), 64'(want.active_index));
        if (got.last_switch_time !== want.last_switch_time)
          flag_mismatch("last_switch_time", got.last_switch_time, want.last_switch_time);
        if (got.channel_merit !== want.channel_merit)
          flag_mismatch("channel_merit", 64'(got.channel_merit), 64'(want.channel_merit));
        if (got.channel_time !== want.channel_time)
          flag_mismatch("channel_time", got.channel_time, want.channel_time);
      end
      n_checked++;
    end
  end

  // Stimulus
  initial begin : stimulus
    int          p;
    int          i;
    int          n;
    script_row_t row;
    rsp_t        none;
    none = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (i = 0; i < NUM_CH; i++) begin
      merit_tab[i] = '0;
      stamp_tab[i] = '0;
    end

    // Reset state, rejected arguments and the first switch
    plan_checked(OP_READ, 3'd0, 32'h0, 1'b0, 64'd0,
                 rsp_t'{1'b0, WHY_NONE, 3'd0, 64'd0, 32'd0, 64'd0});
    plan_checked(OP_READ, 3'd1, 32'h0, 1'b0, 64'd7,
                 rsp_t'{1'b1, WHY_NONE, 3'd0, 64'd0, 32'd0, 64'd0});
    plan_checked(OP_UNUSED, 3'd0, 32'h1234, 1'b0, 64'd9,
                 rsp_t'{1'b1, WHY_NONE, 3'd0, 64'd0, 32'd0, 64'd0});
    plan_checked(OP_UPDATE, 3'd0, 32'h5, 1'b0, 64'd0,
                 rsp_t'{1'b1, WHY_NONE, 3'd0, 64'd0, 32'd0, 64'd0});
    plan_checked(OP_UPDATE, 3'd0, 32'h7FFF_FFFF, 1'b0, 64'd1,
                 rsp_t'{1'b0, WHY_INITIAL, 3'd0, 64'd1, 32'h7FFF_FFFF, 64'd1});
    plan_write(REG_COUNT, 32'd8);
    plan_write(REG_TIMEOUT, 32'd1000);
    plan_write(REG_INTERVAL, 32'd500);
    plan_write(REG_HYST, 32'd65536);
    // Missing merit, exact bar at the top of the range, most negative merit
    plan_item(OP_UPDATE, 3'd1, 32'h0000_0123, 1'b1, 64'd100);
    plan_item(OP_UPDATE, 3'd2, 32'h7FFF_FFFF, 1'b0, 64'd200);
    plan_item(OP_UPDATE, 3'd2, 32'h8000_0000, 1'b0, 64'd300);
    // Timeout, then merit equal to bar, interval not passed, interval met
    plan_item(OP_UPDATE, 3'd3, 32'h0002_0000, 1'b0, 64'd1002);
    plan_item(OP_UPDATE, 3'd4, 32'h0003_0000, 1'b0, 64'd1100);
    plan_item(OP_UPDATE, 3'd4, 32'h0003_0001, 1'b0, 64'd1501);
    plan_item(OP_UPDATE, 3'd4, 32'h0003_0001, 1'b0, 64'd1502);
    // Override at time zero re-arms the initial switch
    plan_item(OP_OVERRIDE, 3'd7, 32'h0, 1'b0, 64'd0);
    plan_item(OP_READ, 3'd7, 32'h0, 1'b0, 64'd0);
    plan_item(OP_UPDATE, 3'd5, 32'hFFFF_0000, 1'b0, 64'd2000);
    plan_item(OP_OVERRIDE, 3'd6, 32'hA5A5_5A5A, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    // Time sums that wrap past 2^64
    plan_write(REG_TIMEOUT, 32'hFFFF_FFFF);
    plan_write(REG_INTERVAL, 32'hFFFF_FFFF);
    plan_item(OP_UPDATE, 3'd1, 32'h0001_0000, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_item(OP_UPDATE, 3'd2, 32'h7FFF_0000, 1'b0, 64'd5);
    plan_item(OP_UPDATE, 3'd3, 32'h7FFF_0000, 1'b1, 64'd6);
    // No channel in use, then more in use than exist
    plan_write(REG_COUNT, 32'd0);
    plan_item(OP_READ, 3'd0, 32'h0, 1'b0, 64'd0);
    plan_item(OP_OVERRIDE, 3'd0, 32'h0, 1'b0, 64'd3);
    plan_write(REG_COUNT, 32'd15);
    plan_item(OP_READ, 3'd7, 32'h0, 1'b0, 64'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed script
    foreach (script[k]) begin
      row = script[k];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        offer(row.item, row.typed, row.want);
      end
    end

    // Randomised phases, each with its own register setting
    for (p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(REG_TIMEOUT, 32'd1500);
          write_reg(REG_HYST, 32'd65536);
          write_reg(REG_INTERVAL, 32'd0);
          write_reg(REG_COUNT, 32'd8);
        end
        1: begin
          write_reg(REG_TIMEOUT, 32'd1);
          write_reg(REG_HYST, 32'd0);
          write_reg(REG_INTERVAL, 32'd0);
          write_reg(REG_COUNT, 32'd4);
        end
        2: begin
          write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
          write_reg(REG_HYST, 32'h7FFF_FFFF);
          write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
          write_reg(REG_COUNT, 32'd8);
          now_us = 64'hFFFF_FFFF_FFFF_F000;
        end
        3: begin
          write_reg(REG_TIMEOUT, $urandom_range(100, 3000));
          write_reg(REG_HYST, $urandom_range(0, 32'h0004_0000));
          write_reg(REG_INTERVAL, $urandom_range(0, 2000));
          write_reg(REG_COUNT, 32'd8);
        end
        4: begin
          write_reg(REG_TIMEOUT, $urandom);
          write_reg(REG_HYST, 32'd0);
          write_reg(REG_INTERVAL, $urandom_range(0, 800));
          write_reg(REG_COUNT, 32'd15);
        end
        5: begin
          write_reg(REG_TIMEOUT, 32'd800);
          write_reg(REG_HYST, 32'h0002_0000);
          write_reg(REG_INTERVAL, 32'd300);
          write_reg(REG_COUNT, 32'd1);
        end
        6: begin
          write_reg(REG_TIMEOUT, 32'd2000);
          write_reg(REG_HYST, $urandom);
          write_reg(REG_INTERVAL, 32'd100);
          write_reg(REG_COUNT, 32'd0);
        end
        default: begin
          write_reg(REG_TIMEOUT, $urandom_range(1, 2500));
          write_reg(REG_HYST, $urandom_range(0, 32'h0003_0000));
          write_reg(REG_INTERVAL, $urandom_range(0, 600));
          write_reg(REG_COUNT, $urandom_range(2, 8));
        end
      endcase
      src_gaps  = (p % 3 != 1);
      sink_gaps = src_gaps;
      n = (chan_count == 0) ? 40 : 215;
      for (i = 0; i < n; i++) begin
        // Long result stall while the sender keeps pushing
        if (i == 100 && (p == 0 || p == 4)) sink_hold = 40;
        // Sender pause until the pipe is empty
        if (i == 120 && (p == 3 || p == 5)) settle();
        offer(random_item(), 1'b0, none);
      end
    end

    settle();
    $display("sent %0d transactions, checked %0d results (%0d rejected, %0d overrides)",
             n_sent, n_checked, n_rejected, n_override);
    $display("switches: initial %0d, timeout %0d, better merit %0d",
             reason_tally[WHY_INITIAL], reason_tally[WHY_TIMEOUT], reason_tally[WHY_MERIT]);
    if (n_errors == 0 && awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin : watchdog
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/rcs_pkg.sv
design/rcs_cfg_regs.sv
design/rcs_core.sv
design/redundant_channel_selector.sv
dv/redundant_channel_selector_tb.sv
